[rtl/indexed_table_with_shift_delete_defines.svh]
// Assertion macros for the ordered word table.
`ifndef INDEXED_TABLE_WITH_SHIFT_DELETE_DEFINES_SVH
`define INDEXED_TABLE_WITH_SHIFT_DELETE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define ITSD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("itsd: implication check failed");
// Next-cycle implication, checked outside reset
`define ITSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("itsd: next-cycle check failed");
`else
`define ITSD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ITSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/itsd_pkg.sv]
// Shared types and constants for the ordered word table.
`default_nettype none

package itsd_pkg;

    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Operation codes, in dispatch order
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic [COUNT_W-1:0]  capacity;
    } out_t;

    // Datapath actions driven by the microcode
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_APPEND,
        ACT_RD_ISSUE,
        ACT_RD_CAPTURE,
        ACT_WRITE,
        ACT_SET_RANGE,
        ACT_SET_FULL,
        ACT_DEL_PRIME,
        ACT_DEL_MOVE,
        ACT_DEL_FINISH,
        ACT_EMIT
    } act_t;

    typedef struct packed {
        act_t act;
    } ctrl_t;

    // Test results returned from the datapath to the sequencer
    typedef struct packed {
        logic              in_valid;
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              range;
        logic              no_move;
        logic              more;
        logic              out_free;
    } flags_t;

endpackage

`default_nettype wire

[rtl/indexed_table_with_shift_delete.sv]
// Top level of the ordered word table: sequencer, datapath and checks.
`default_nettype none
`include "indexed_table_with_shift_delete_defines.svh"

// Ordered table of up to DEPTH words with append, indexed read, indexed write and
// delete-with-shift; every transaction on s_ returns exactly one result on m_
// carrying the read word, a status code, and the entry count and logical capacity
// after the operation. Capacity starts at the smaller of INITIAL_CAPACITY and DEPTH,
// doubles (capped at DEPTH) when an append finds it full and halves when a delete
// leaves a nonzero count equal to a quarter of it. Each transaction runs through a
// short microprogram, one step per cycle; a delete at index i also moves every
// later entry down one place, one per cycle, through the single write port of the
// entry store. A result that is not taken holds the sequencer in its final step;
// the next transaction may be accepted while the previous result still waits on m_.

module indexed_table_with_shift_delete
    import itsd_pkg::*;
#(
    parameter int DEPTH            = 64,
    parameter int INITIAL_CAPACITY = 4,
    parameter int DATA_WIDTH       = 32
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    ctrl_t  ctrl;
    flags_t flags;

    itsd_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    itsd_dp #(
        .DEPTH            (DEPTH),
        .INITIAL_CAPACITY (INITIAL_CAPACITY),
        .DATA_WIDTH       (DATA_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .flags   (flags)
    );

    // A transaction always needs a check step before the next can be taken
    `ITSD_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // Appends only run with room left in the store
    `ITSD_ASSERT_IMP(a_append_has_room, aclk, aresetn, ctrl.act == ACT_APPEND, !flags.full)
    // Shift moves stay strictly inside the filled part of the store
    `ITSD_ASSERT_IMP(a_move_in_range, aclk, aresetn, ctrl.act == ACT_DEL_MOVE, !flags.range && !flags.no_move)
    // A new result only appears after the emit step
    `ITSD_ASSERT_IMP(a_result_from_emit, aclk, aresetn, $rose(m_valid), $past(ctrl.act == ACT_EMIT))

endmodule

`default_nettype wire

[rtl/itsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module itsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/itsd_seq.sv]
// Microcode sequencer: step counter, control store and jump logic.
`default_nettype none

module itsd_seq
    import itsd_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire flags_t flags,
    output ctrl_t       ctrl
);

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // Program addresses; the four operation checks sit at OP_BASE + kind
    localparam step_t S_FETCH      = 4'd0;
    localparam step_t S_OP_BASE    = 4'd1;
    localparam step_t S_OP_APPEND  = 4'd1;
    localparam step_t S_OP_READ    = 4'd2;
    localparam step_t S_OP_WRITE   = 4'd3;
    localparam step_t S_OP_DELETE  = 4'd4;
    localparam step_t S_DO_APPEND  = 4'd5;
    localparam step_t S_RD_ISSUE   = 4'd6;
    localparam step_t S_RD_CAPTURE = 4'd7;
    localparam step_t S_DO_WRITE   = 4'd8;
    localparam step_t S_SET_RANGE  = 4'd9;
    localparam step_t S_SET_FULL   = 4'd10;
    localparam step_t S_DEL_PRIME  = 4'd11;
    localparam step_t S_DEL_MOVE   = 4'd12;
    localparam step_t S_DEL_FINISH = 4'd13;
    localparam step_t S_EMIT       = 4'd14;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_FULL,
        C_RANGE,
        C_NO_MOVE,
        C_MORE,
        C_OUT_FREE
    } cond_t;

    // One control word: action, branch test, dispatch flag, taken / not-taken targets
    typedef struct packed {
        act_t  act;
        cond_t cond;
        logic  disp;
        step_t jmp;
        step_t alt;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        w = '{act: ACT_NONE, cond: C_ALWAYS, disp: 1'b0, jmp: S_FETCH, alt: S_FETCH};
        unique case (s)
            S_FETCH:      w = '{ACT_ACCEPT,     C_IN_VALID, 1'b1, S_OP_BASE,   S_FETCH};
            S_OP_APPEND:  w = '{ACT_NONE,       C_FULL,     1'b0, S_SET_FULL,  S_DO_APPEND};
            S_OP_READ:    w = '{ACT_NONE,       C_RANGE,    1'b0, S_SET_RANGE, S_RD_ISSUE};
            S_OP_WRITE:   w = '{ACT_NONE,       C_RANGE,    1'b0, S_SET_RANGE, S_DO_WRITE};
            S_OP_DELETE:  w = '{ACT_NONE,       C_RANGE,    1'b0, S_SET_RANGE, S_DEL_PRIME};
            S_DO_APPEND:  w = '{ACT_APPEND,     C_ALWAYS,   1'b0, S_EMIT,      S_EMIT};
            S_RD_ISSUE:   w = '{ACT_RD_ISSUE,   C_ALWAYS,   1'b0, S_RD_CAPTURE, S_RD_CAPTURE};
            S_RD_CAPTURE: w = '{ACT_RD_CAPTURE, C_ALWAYS,   1'b0, S_EMIT,      S_EMIT};
            S_DO_WRITE:   w = '{ACT_WRITE,      C_ALWAYS,   1'b0, S_EMIT,      S_EMIT};
            S_SET_RANGE:  w = '{ACT_SET_RANGE,  C_ALWAYS,   1'b0, S_EMIT,      S_EMIT};
            S_SET_FULL:   w = '{ACT_SET_FULL,   C_ALWAYS,   1'b0, S_EMIT,      S_EMIT};
            S_DEL_PRIME:  w = '{ACT_DEL_PRIME,  C_NO_MOVE,  1'b0, S_DEL_FINISH, S_DEL_MOVE};
            S_DEL_MOVE:   w = '{ACT_DEL_MOVE,   C_MORE,     1'b0, S_DEL_MOVE,  S_DEL_FINISH};
            S_DEL_FINISH: w = '{ACT_DEL_FINISH, C_ALWAYS,   1'b0, S_EMIT,      S_EMIT};
            S_EMIT:       w = '{ACT_EMIT,       C_OUT_FREE, 1'b0, S_FETCH,     S_EMIT};
            default:      w = '{ACT_NONE,       C_ALWAYS,   1'b0, S_FETCH,     S_FETCH};
        endcase
        return w;
    endfunction

    step_t  upc_reg;
    step_t  upc_next;
    ucode_t uword;
    logic   cond_met;

    assign uword = ucode_rom(upc_reg);

    // Branch test select
    always_comb begin
        unique case (uword.cond)
            C_ALWAYS:   cond_met = 1'b1;
            C_IN_VALID: cond_met = flags.in_valid;
            C_FULL:     cond_met = flags.full;
            C_RANGE:    cond_met = flags.range;
            C_NO_MOVE:  cond_met = flags.no_move;
            C_MORE:     cond_met = flags.more;
            C_OUT_FREE: cond_met = flags.out_free;
            default:    cond_met = 1'b1;
        endcase
    end

    // Next step: taken target (optionally offset by the operation code) or fall-back
    always_comb begin
        if (cond_met) begin
            if (uword.disp) begin
                upc_next = step_t'(uword.jmp + step_t'(flags.kind));
            end else begin
                upc_next = uword.jmp;
            end
        end else begin
            upc_next = uword.alt;
        end
    end

    // Control outputs
    always_comb begin
        ctrl.act = uword.act;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= S_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

[rtl/itsd_dp.sv]
// Datapath: entry store, count and capacity, pointer, result register.
`default_nettype none

module itsd_dp
    import itsd_pkg::*;
#(
    parameter int DEPTH            = 64,
    parameter int INITIAL_CAPACITY = 4,
    parameter int DATA_WIDTH       = 32
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire ctrl_t ctrl,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire in_t   s_data,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_t       m_data,
    output flags_t     flags
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW0  = $clog2(DEPTH + 1);
    localparam int CW   = (CW0 > COUNT_W) ? CW0 : COUNT_W;
    localparam int CAP0 = (INITIAL_CAPACITY < DEPTH) ? INITIAL_CAPACITY : DEPTH;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_X = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] CAP0_C  = CW'(CAP0);

    logic [CW-1:0]         ptr_reg, ptr_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         cap_reg, cap_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [DATA_W-1:0]     rd_reg, rd_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    out_t                  out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic [CW:0]           ptr_p1, ptr_p2, cnt_x, grown;
    logic [CW-1:0]         cnt_dec;
    logic [DATA_WIDTH-1:0] in_val_w;
    logic [DATA_W-1:0]     rdata_w;
    logic                  emit_fire;
    logic                  out_free;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    itsd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Width adjustment between the word ports and the stored width
    assign in_val_w = DATA_WIDTH'(s_data.value);
    assign rdata_w  = DATA_W'(ram_rdata);

    assign ptr_p1  = {1'b0, ptr_reg} + (CW + 1)'(1);
    assign ptr_p2  = {1'b0, ptr_reg} + (CW + 1)'(2);
    assign cnt_x   = {1'b0, cnt_reg};
    assign grown   = {cap_reg, 1'b0};
    assign cnt_dec = cnt_reg - CW'(1);

    assign out_free  = !out_valid_reg || m_ready;
    assign emit_fire = (ctrl.act == ACT_EMIT) && out_free;

    // No transaction is taken while reset is held
    assign s_ready = aresetn && (ctrl.act == ACT_ACCEPT);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Branch tests for the sequencer
    always_comb begin
        flags.in_valid = s_valid;
        flags.kind     = s_data.kind;
        flags.full     = (cnt_reg == DEPTH_C);
        flags.range    = !(ptr_reg < cnt_reg);
        flags.no_move  = (ptr_p1 >= cnt_x);
        flags.more     = (ptr_p2 < cnt_x);
        flags.out_free = out_free;
    end

    // Action decode
    always_comb begin
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        cap_next    = cap_reg;
        val_next    = val_reg;
        rd_next     = rd_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = ptr_reg[AW-1:0];
        ram_wdata   = val_reg;
        ram_raddr   = ptr_reg[AW-1:0];
        unique case (ctrl.act)
            ACT_ACCEPT: begin
                if (s_valid) begin
                    ptr_next    = CW'(s_data.index);
                    val_next    = in_val_w;
                    rd_next     = '0;
                    status_next = ST_OK;
                end
            end
            ACT_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg >= cap_reg) begin
                    cap_next = (grown > DEPTH_X) ? DEPTH_C : grown[CW-1:0];
                end
            end
            ACT_RD_ISSUE: begin
                ram_raddr = ptr_reg[AW-1:0];
            end
            ACT_RD_CAPTURE: begin
                rd_next = rdata_w;
            end
            ACT_WRITE: begin
                ram_we = 1'b1;
            end
            ACT_SET_RANGE: begin
                status_next = ST_RANGE;
            end
            ACT_SET_FULL: begin
                status_next = ST_FULL;
            end
            ACT_DEL_PRIME: begin
                ram_raddr = ptr_p1[AW-1:0];
            end
            ACT_DEL_MOVE: begin
                // write the word fetched last cycle one place down, fetch the next
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                ram_raddr = ptr_p2[AW-1:0];
                ptr_next  = ptr_p1[CW-1:0];
            end
            ACT_DEL_FINISH: begin
                cnt_next = cnt_dec;
                if ((cnt_dec != '0) && (cnt_dec == (cap_reg >> 2))) begin
                    cap_next = cap_reg >> 1;
                end
            end
            ACT_EMIT: begin
            end
            ACT_NONE: begin
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit_fire) begin
            out_next.read_data = rd_reg;
            out_next.status    = status_reg;
            out_next.count     = cnt_reg[COUNT_W-1:0];
            out_next.capacity  = cap_reg[COUNT_W-1:0];
            out_valid_next     = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            cap_reg       <= CAP0_C;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        val_reg    <= val_next;
        rd_reg     <= rd_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the ordered word table with shift-on-delete.
`timescale 1ns / 1ps

module tb
    import itsd_pkg::*;
();

    localparam int TABLE_DEPTH = 64;
    localparam int INIT_CAP    = 4;
    localparam int CYCLE_LIMIT = 400000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    // Shadow copy of the table contents, count and capacity
    logic [DATA_W-1:0] shadow_words [TABLE_DEPTH];
    int                shadow_count;
    int                shadow_cap;

    out_t due_replies [$];
    int   mismatches;
    int   cycle_count;
    bit   idle_on;
    int   ready_hold_req;

    indexed_table_with_shift_delete #(
        .DEPTH            (TABLE_DEPTH),
        .INITIAL_CAPACITY (INIT_CAP),
        .DATA_WIDTH       (DATA_W)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Applies one operation to the shadow table and returns the reply it should give
    function automatic out_t apply_table_op(in_t op);
        out_t reply;
        reply        = '0;
        reply.status = ST_OK;
        case (op.kind)
            KIND_APPEND: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    if (shadow_count >= shadow_cap)
                        shadow_cap = (shadow_cap * 2 > TABLE_DEPTH) ? TABLE_DEPTH
                                                                    : shadow_cap * 2;
                    shadow_words[shadow_count] = op.value;
                    shadow_count++;
                end
            end
            KIND_READ: begin
                if (op.index < shadow_count)
                    reply.read_data = shadow_words[op.index];
                else
                    reply.status = ST_RANGE;
            end
            KIND_WRITE: begin
                if (op.index < shadow_count)
                    shadow_words[op.index] = op.value;
                else
                    reply.status = ST_RANGE;
            end
            default: begin
                if (op.index >= shadow_count) begin
                    reply.status = ST_RANGE;
                end else begin
                    // later entries close the gap
                    for (int i = op.index; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_count--;
                    if (shadow_count > 0 && shadow_count == shadow_cap / 4)
                        shadow_cap = shadow_cap / 2;
                end
            end
        endcase
        reply.count    = shadow_count[COUNT_W-1:0];
        reply.capacity = shadow_cap[COUNT_W-1:0];
        return reply;
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return $urandom;
    endfunction

    // Random operation; weights in percent for append and delete, rest split read/write
    function automatic in_t pick_op(int w_append, int w_delete);
        in_t op;
        int  r;
        r = $urandom_range(0, 99);
        if (r < w_append)
            op.kind = KIND_APPEND;
        else if (r < w_append + w_delete)
            op.kind = KIND_DELETE;
        else if (r[0])
            op.kind = KIND_READ;
        else
            op.kind = KIND_WRITE;
        if (shadow_count > 0 && $urandom_range(0, 99) < 85)
            op.index = $urandom_range(0, shadow_count - 1);
        else
            op.index = $urandom_range(0, 63);
        op.value = pick_word();
        return op;
    endfunction

    // Offers one transaction, waits for acceptance and records the reply due
    task automatic send_item(in_t op);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        do @(posedge aclk); while (!s_ready);
        due_replies.push_back(apply_table_op(op));
    endtask

    task automatic send_op(logic [KIND_W-1:0] kind, int index, logic [VALUE_W-1:0] value);
        in_t op;
        op.kind  = kind;
        op.index = index[INDEX_W-1:0];
        op.value = value;
        send_item(op);
    endtask

    // Result side: random stalls, plus long hold-offs on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_hold_req > 0) begin
                hold_left      = ready_hold_req;
                ready_hold_req = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic flag_reply(string why, out_t want, out_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: want data=%h st=%0d cnt=%0d cap=%0d, got data=%h st=%0d cnt=%0d cap=%0d",
                     $realtime, why, want.read_data, want.status, want.count, want.capacity,
                     got.read_data, got.status, got.count, got.capacity);
    endtask

    // Reply checker
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_replies.size() == 0) begin
                flag_reply("unexpected reply", '0, m_data);
            end else begin
                want = due_replies.pop_front();
                if (m_data.read_data !== want.read_data || m_data.status !== want.status ||
                    m_data.count !== want.count || m_data.capacity !== want.capacity)
                    flag_reply("reply mismatch", want, m_data);
            end
        end
    end

    // Accesses to an empty table are all out of range
    task automatic test_empty_table();
        send_op(KIND_READ, 0, 32'h0000_0000);
        send_op(KIND_WRITE, 63, 32'hFFFF_FFFF);
        send_op(KIND_DELETE, 0, 32'h0000_0000);
    endtask

    // Appends past the initial capacity, then reads and writes by index
    task automatic test_growth_and_access();
        send_op(KIND_APPEND, 0, 32'h0000_0000);
        send_op(KIND_APPEND, 63, 32'hFFFF_FFFF);
        send_op(KIND_APPEND, 0, 32'hAAAA_AAAA);
        send_op(KIND_APPEND, 0, 32'h5555_5555);
        send_op(KIND_APPEND, 0, 32'h1234_5678);
        send_op(KIND_READ, 0, 32'hFFFF_FFFF);
        send_op(KIND_READ, 4, 32'h0000_0000);
        send_op(KIND_WRITE, 1, 32'h0000_0000);
        send_op(KIND_READ, 1, 32'h0000_0000);
        send_op(KIND_READ, 5, 32'h0000_0000);
        send_op(KIND_WRITE, 5, 32'hDEAD_BEEF);
    endtask

    // Deletes that shift, halve the capacity and finally empty the table
    task automatic test_shrink_on_delete();
        send_op(KIND_DELETE, 0, 32'h0000_0000);
        send_op(KIND_DELETE, 2, 32'h0000_0000);
        send_op(KIND_DELETE, 1, 32'h0000_0000);
        send_op(KIND_DELETE, 1, 32'h0000_0000);
        send_op(KIND_DELETE, 0, 32'h0000_0000);
        send_op(KIND_DELETE, 0, 32'h0000_0000);
        send_op(KIND_READ, 0, 32'h0000_0000);
    endtask

    // Fill to depth, append into a full store, longest shift, then drain at random
    task automatic test_full_store();
        in_t op;
        while (shadow_count < TABLE_DEPTH)
            send_op(KIND_APPEND, $urandom_range(0, 63), pick_word());
        send_op(KIND_APPEND, 0, 32'hFFFF_FFFF);
        send_op(KIND_APPEND, 63, $urandom);
        send_op(KIND_READ, 63, 32'h0000_0000);
        send_op(KIND_WRITE, 63, 32'hFFFF_FFFF);
        send_op(KIND_READ, 63, 32'h0000_0000);
        send_op(KIND_DELETE, 0, 32'h0000_0000);
        send_op(KIND_DELETE, 63, 32'h0000_0000);
        while (shadow_count > 0) begin
            op = pick_op(10, 70);
            send_item(op);
        end
    endtask

    // Alternating growth and shrink phases with random content
    task automatic test_random_mix();
        in_t op;
        for (int i = 0; i < 175; i++) begin
            if ((i / 50) % 2 == 0)
                op = pick_op(55, 15);
            else
                op = pick_op(15, 50);
            send_item(op);
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_no_idle_burst();
        idle_on = 1'b0;
        for (int i = 0; i < 50; i++)
            send_item(pick_op(35, 30));
        idle_on = 1'b1;
    endtask

    // Result side holds off while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        idle_on        = 1'b0;
        ready_hold_req = 300;
        for (int i = 0; i < 20; i++)
            send_item(pick_op(40, 30));
        idle_on = 1'b1;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        idle_on        = 1'b1;
        ready_hold_req = 0;
        mismatches     = 0;
        cycle_count    = 0;
        shadow_count   = 0;
        shadow_cap     = INIT_CAP;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_table();
        test_growth_and_access();
        test_shrink_on_delete();
        test_full_store();
        test_random_mix();
        test_no_idle_burst();
        test_output_backpressure();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge aclk);
        repeat (TABLE_DEPTH + 8) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[indexed_table_with_shift_delete.f]
+incdir+rtl
rtl/itsd_pkg.sv
rtl/itsd_ram.sv
rtl/itsd_seq.sv
rtl/itsd_dp.sv
rtl/indexed_table_with_shift_delete.sv
verif/tb.sv
